// ===== rtl/core/cst_pkg.sv =====
package cst_pkg;

    localparam int SLOTS  = 256;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int CAP_W  = 9;
    localparam int CAP_MAX = (SLOTS < 256) ? SLOTS : 256;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    localparam logic [CAP_W-1:0]  RST_CAPACITY    = CAP_W'(CAP_MAX);
    localparam logic [31:0]       RST_TABLE_ID    = 32'd1;
    localparam logic [7:0]        RST_ROOT_RIGHTS = 8'd15;
    localparam logic [CAP_W-1:0]  RST_TYPE_COUNT  = CAP_W'(16);
    localparam logic [7:0]        ROOT_TYPE       = 8'd0;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_INSERT = 2'd2,
        OP_LOOKUP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_INVALID  = 2'd1,
        STS_NO_FREE  = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SS_FREE     = 2'd0,
        SS_RESERVED = 2'd1,
        SS_VALID    = 2'd2
    } t_slot_state;

    typedef enum logic [1:0] {
        REG_CAPACITY    = 2'd0,
        REG_TABLE_ID    = 2'd1,
        REG_ROOT_RIGHTS = 2'd2,
        REG_TYPE_COUNT  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_slot_state       state;
        logic [LINK_W-1:0] next;
    } t_link;

    typedef struct packed {
        logic [7:0]  obj_kind;
        logic [7:0]  rights;
        logic [15:0] badge;
        logic        has_parent;
        logic [7:0]  parent;
    } t_meta;

    typedef struct packed {
        t_meta       meta;
        logic [31:0] object;
    } t_entry;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [31:0]      table_id;
        logic [7:0]       root_rights;
        logic [CAP_W-1:0] type_count;
        logic             restart;
    } t_cfg;

    function automatic t_link link_default(input logic [SLOT_W-1:0] idx,
                                           input logic [CAP_W-1:0] cap);
        t_link             l;
        logic [LINK_W-1:0] nxt;
        nxt = LINK_W'(idx) + LINK_W'(1);
        l.state = (idx == '0) ? SS_VALID : SS_FREE;
        l.next  = ((idx != '0) && (CAP_W'(nxt) < cap)) ? nxt : NIL;
        return l;
    endfunction

endpackage

// ===== rtl/core/cst_cfg.sv =====
module cst_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cst_pkg::t_cfg         o_cfg
);

    logic [cst_pkg::CAP_W-1:0] r_capacity;
    logic [31:0]               r_table_id;
    logic [7:0]                r_root_rights;
    logic [cst_pkg::CAP_W-1:0] r_type_count;
    logic                      r_restart;
    logic                      wr_en;
    logic [cst_pkg::CAP_W-1:0] cap_clamped;
    cst_pkg::t_reg_idx         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = cst_pkg::t_reg_idx'(paddr[3:2]);

    always_comb begin
        cap_clamped = pwdata[cst_pkg::CAP_W-1:0];
        if (cap_clamped == '0) begin
            cap_clamped = cst_pkg::CAP_W'(1);
        end else if (cap_clamped > cst_pkg::CAP_W'(cst_pkg::CAP_MAX)) begin
            cap_clamped = cst_pkg::CAP_W'(cst_pkg::CAP_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity    <= cst_pkg::RST_CAPACITY;
            r_table_id    <= cst_pkg::RST_TABLE_ID;
            r_root_rights <= cst_pkg::RST_ROOT_RIGHTS;
            r_type_count  <= cst_pkg::RST_TYPE_COUNT;
            r_restart     <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (wr_en) begin
                unique case (idx)
                    cst_pkg::REG_CAPACITY: begin
                        r_capacity <= cap_clamped;
                        r_restart  <= 1'b1;
                    end
                    cst_pkg::REG_TABLE_ID:    r_table_id    <= pwdata;
                    cst_pkg::REG_ROOT_RIGHTS: r_root_rights <= pwdata[7:0];
                    cst_pkg::REG_TYPE_COUNT:  r_type_count  <= pwdata[cst_pkg::CAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            cst_pkg::REG_CAPACITY:    prdata = 32'(r_capacity);
            cst_pkg::REG_TABLE_ID:    prdata = r_table_id;
            cst_pkg::REG_ROOT_RIGHTS: prdata = 32'(r_root_rights);
            cst_pkg::REG_TYPE_COUNT:  prdata = 32'(r_type_count);
            default:                  prdata = '0;
        endcase
    end

    // restart is seen in the cycle after the write, with the new capacity
    assign o_cfg.capacity    = r_capacity;
    assign o_cfg.table_id    = r_table_id;
    assign o_cfg.root_rights = r_root_rights;
    assign o_cfg.type_count  = r_type_count;
    assign o_cfg.restart     = r_restart;

endmodule

// ===== rtl/core/cst_link.sv =====
module cst_link (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic [cst_pkg::CAP_W-1:0]  i_capacity,
    input  logic                       i_rd_en,
    input  logic [cst_pkg::SLOT_W-1:0] i_addr_a,
    input  logic [cst_pkg::SLOT_W-1:0] i_addr_b,
    input  logic                       i_we,
    input  logic [cst_pkg::SLOT_W-1:0] i_wr_addr,
    input  cst_pkg::t_link             i_wr_data,
    output cst_pkg::t_link             o_link_a,
    output cst_pkg::t_link             o_link_b
);

    cst_pkg::t_link             r_mem [cst_pkg::SLOTS];
    logic [cst_pkg::SLOTS-1:0]  r_written;
    logic [cst_pkg::SLOT_W-1:0] r_addr_a;
    logic [cst_pkg::SLOT_W-1:0] r_addr_b;
    cst_pkg::t_link             r_data_a;
    cst_pkg::t_link             r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data_a <= r_mem[i_addr_a];
            r_data_b <= r_mem[i_addr_b];
            r_addr_a <= i_addr_a;
            r_addr_b <= i_addr_b;
        end
    end

    // entries not written since restart read as the initial chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_written <= '0;
        end else if (i_we) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    assign o_link_a = r_written[r_addr_a] ? r_data_a
                                          : cst_pkg::link_default(r_addr_a, i_capacity);
    assign o_link_b = r_written[r_addr_b] ? r_data_b
                                          : cst_pkg::link_default(r_addr_b, i_capacity);

endmodule

// ===== rtl/core/cst_entry.sv =====
module cst_entry (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cst_pkg::t_cfg              i_cfg,
    input  logic                       i_rd_en,
    input  logic [cst_pkg::SLOT_W-1:0] i_rd_addr,
    input  logic                       i_we,
    input  logic [cst_pkg::SLOT_W-1:0] i_wr_addr,
    input  cst_pkg::t_entry            i_wr_data,
    output cst_pkg::t_entry            o_rd_data
);

    cst_pkg::t_entry            r_mem [cst_pkg::SLOTS];
    cst_pkg::t_entry            r_rd_data;
    logic [cst_pkg::SLOT_W-1:0] r_rd_addr;
    logic                       r_root_live;
    logic [31:0]                r_root_id;
    logic [7:0]                 r_root_rights;
    cst_pkg::t_entry            root;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // slot 0 holds the root until an insert overwrites it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_live   <= 1'b1;
            r_root_id     <= cst_pkg::RST_TABLE_ID;
            r_root_rights <= cst_pkg::RST_ROOT_RIGHTS;
        end else if (i_cfg.restart) begin
            r_root_live   <= 1'b1;
            r_root_id     <= i_cfg.table_id;
            r_root_rights <= i_cfg.root_rights;
        end else if (i_we && (i_wr_addr == '0)) begin
            r_root_live <= 1'b0;
        end
    end

    always_comb begin
        root                 = '0;
        root.meta.obj_kind   = cst_pkg::ROOT_TYPE;
        root.meta.rights     = r_root_rights;
        root.object          = r_root_id;
    end

    assign o_rd_data = (r_root_live && (r_rd_addr == '0)) ? root : r_rd_data;

endmodule

// ===== rtl/core/capability_slot_table.sv =====
// Capability slot table. One operation (alloc, free, insert, lookup) is taken
// when start is high and busy is low; busy then stays high for one cycle while
// the slot memories are read, checked and written back, and the result follows
// on the o_ ports with o_done high for exactly one cycle. The slot memories
// are read through registered outputs before the write-back; a new start may
// be given in the cycle the result is shown. The result cannot be held off, so
// capture it when o_done is high. Writing capacity restarts the table
// immediately, with no clearing pass; write registers only while no operation
// is in flight.
module capability_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_slot,
    input  logic [7:0]  i_obj_kind,
    input  logic [31:0] i_kobj_id,
    input  logic [7:0]  i_rights,
    input  logic [15:0] i_badge,
    input  logic        i_has_parent,
    input  logic [7:0]  i_parent_slot,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot_out,
    output logic [7:0]  o_entry_type,
    output logic [7:0]  o_entry_rights,
    output logic [15:0] o_entry_badge,
    output logic [31:0] o_entry_id,
    output logic        o_entry_has_parent,
    output logic [7:0]  o_entry_parent,
    output logic [8:0]  o_live_total,
    output logic [8:0]  o_spare_total,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    cst_pkg::t_cfg                cfg;
    cst_pkg::t_op                 r_op;
    logic [7:0]                   r_slot;
    logic [7:0]                   r_ktype;
    logic [31:0]                  r_kid;
    logic [7:0]                   r_rights;
    logic [15:0]                  r_badge;
    logic                         r_hasp;
    logic [7:0]                   r_pslot;
    logic [cst_pkg::LINK_W-1:0]   r_free_head, n_free_head;
    logic [cst_pkg::CAP_W-1:0]    r_valid_count, n_valid_count;

    logic                         r_done;
    cst_pkg::t_status             r_status, n_status;
    logic [7:0]                   r_slot_out, n_slot_out;
    cst_pkg::t_entry              r_entry_out, n_entry_out;

    logic                         accept;
    logic [cst_pkg::LINK_W-1:0]   head_now;
    logic [cst_pkg::SLOT_W-1:0]   addr_a;
    cst_pkg::t_link               link_a, link_b;
    logic                         link_we;
    logic [cst_pkg::SLOT_W-1:0]   link_waddr;
    cst_pkg::t_link               link_wdata;
    logic                         ent_we;
    cst_pkg::t_entry              ent_wdata;
    cst_pkg::t_entry              ent_rdata;
    logic                         slot_in_range;
    logic                         pslot_ok;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;
    // a request taken in the restart cycle sees the restarted head
    assign head_now = cfg.restart ?
                      ((cfg.capacity > cst_pkg::CAP_W'(1)) ?
                       cst_pkg::LINK_W'(1) : cst_pkg::NIL) : r_free_head;
    assign addr_a = (cst_pkg::t_op'(i_op) == cst_pkg::OP_ALLOC) ?
                    head_now[cst_pkg::SLOT_W-1:0] : i_slot;

    cst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cst_link u_link (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (cfg.restart),
        .i_capacity (cfg.capacity),
        .i_rd_en    (accept),
        .i_addr_a   (addr_a),
        .i_addr_b   (i_parent_slot),
        .i_we       (link_we),
        .i_wr_addr  (link_waddr),
        .i_wr_data  (link_wdata),
        .o_link_a   (link_a),
        .o_link_b   (link_b)
    );

    cst_entry u_entry (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_rd_en   (accept),
        .i_rd_addr (i_slot),
        .i_we      (ent_we),
        .i_wr_addr (r_slot),
        .i_wr_data (ent_wdata),
        .o_rd_data (ent_rdata)
    );

    assign slot_in_range = cst_pkg::CAP_W'(r_slot) < cfg.capacity;
    assign pslot_ok      = !r_hasp ||
                           ((cst_pkg::CAP_W'(r_pslot) < cfg.capacity) &&
                            (r_pslot != r_slot) &&
                            (link_b.state == cst_pkg::SS_VALID));

    always_comb begin
        n_state       = r_state;
        n_free_head   = r_free_head;
        n_valid_count = r_valid_count;
        n_status      = cst_pkg::STS_NOTFOUND;
        n_slot_out    = '0;
        n_entry_out   = '0;
        link_we       = 1'b0;
        link_waddr    = r_slot;
        link_wdata    = link_a;
        ent_we        = 1'b0;
        ent_wdata.meta.obj_kind   = r_ktype;
        ent_wdata.meta.rights     = r_rights;
        ent_wdata.meta.badge      = r_badge;
        ent_wdata.meta.has_parent = r_hasp;
        ent_wdata.meta.parent     = r_hasp ? r_pslot : 8'd0;
        ent_wdata.object          = r_kid;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_op)
                    cst_pkg::OP_ALLOC: begin
                        if ((r_free_head == cst_pkg::NIL) ||
                            (cst_pkg::CAP_W'(r_free_head) >= cfg.capacity)) begin
                            n_status = cst_pkg::STS_NO_FREE;
                        end else begin
                            link_we          = 1'b1;
                            link_waddr       = r_free_head[cst_pkg::SLOT_W-1:0];
                            link_wdata.state = cst_pkg::SS_RESERVED;
                            link_wdata.next  = cst_pkg::NIL;
                            n_free_head      = link_a.next;
                            n_slot_out       = r_free_head[7:0];
                            n_status         = cst_pkg::STS_OK;
                        end
                    end
                    cst_pkg::OP_FREE: begin
                        if (slot_in_range && (link_a.state != cst_pkg::SS_FREE)) begin
                            if ((link_a.state == cst_pkg::SS_VALID) &&
                                (r_valid_count != '0)) begin
                                n_valid_count = r_valid_count - cst_pkg::CAP_W'(1);
                            end
                            link_we          = 1'b1;
                            link_wdata.state = cst_pkg::SS_FREE;
                            link_wdata.next  = r_free_head;
                            n_free_head      = cst_pkg::LINK_W'(r_slot);
                            n_status         = cst_pkg::STS_OK;
                        end
                    end
                    cst_pkg::OP_INSERT: begin
                        n_status = cst_pkg::STS_INVALID;
                        if (slot_in_range && (cst_pkg::CAP_W'(r_ktype) < cfg.type_count) &&
                            (link_a.state == cst_pkg::SS_RESERVED) && pslot_ok) begin
                            link_we          = 1'b1;
                            link_wdata.state = cst_pkg::SS_VALID;
                            ent_we           = 1'b1;
                            n_valid_count    = r_valid_count + cst_pkg::CAP_W'(1);
                            n_status         = cst_pkg::STS_OK;
                        end
                    end
                    cst_pkg::OP_LOOKUP: begin
                        if (slot_in_range && (link_a.state == cst_pkg::SS_VALID)) begin
                            n_entry_out = ent_rdata;
                            n_status    = cst_pkg::STS_OK;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_head   <= (cst_pkg::RST_CAPACITY > cst_pkg::CAP_W'(1)) ?
                             cst_pkg::LINK_W'(1) : cst_pkg::NIL;
            r_valid_count <= cst_pkg::CAP_W'(1);
            r_done        <= 1'b0;
        end else if (cfg.restart) begin
            r_state       <= n_state;
            r_free_head   <= (cfg.capacity > cst_pkg::CAP_W'(1)) ?
                             cst_pkg::LINK_W'(1) : cst_pkg::NIL;
            r_valid_count <= cst_pkg::CAP_W'(1);
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_head   <= n_free_head;
            r_valid_count <= n_valid_count;
            r_done        <= (r_state == S_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= cst_pkg::t_op'(i_op);
            r_slot   <= i_slot;
            r_ktype  <= i_obj_kind;
            r_kid    <= i_kobj_id;
            r_rights <= i_rights;
            r_badge  <= i_badge;
            r_hasp   <= i_has_parent;
            r_pslot  <= i_parent_slot;
        end
        if (r_state == S_EXEC) begin
            r_status    <= n_status;
            r_slot_out  <= n_slot_out;
            r_entry_out <= n_entry_out;
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_slot_out         = r_slot_out;
    assign o_entry_type       = r_entry_out.meta.obj_kind;
    assign o_entry_rights     = r_entry_out.meta.rights;
    assign o_entry_badge      = r_entry_out.meta.badge;
    assign o_entry_id         = r_entry_out.object;
    assign o_entry_has_parent = r_entry_out.meta.has_parent;
    assign o_entry_parent     = r_entry_out.meta.parent;
    assign o_live_total       = r_valid_count;
    assign o_spare_total      = cfg.capacity - r_valid_count;

endmodule

// ===== rtl/core/cst_checker.sv =====
module cst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [7:0]  o_slot_out,
    input logic [31:0] o_entry_id,
    input logic [8:0]  o_live_total
);

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_done)
        else $error("operation did not complete in one busy cycle");

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_fail_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != cst_pkg::STS_OK)) |-> (o_slot_out == '0) && (o_entry_id == '0))
        else $error("failed request returned data");

    a_count_moves_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done, 2)) |->
            ((o_live_total == $past(o_live_total, 2)) ||
             (o_live_total == $past(o_live_total, 2) + 9'd1) ||
             (o_live_total == $past(o_live_total, 2) - 9'd1)))
        else $error("used count changed by more than one");

endmodule

bind capability_slot_table cst_checker u_cst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_slot_out   (o_slot_out),
    .o_entry_id   (o_entry_id),
    .o_live_total (o_live_total)
);
